[hdl/tbl_pkg.sv]
// Package for the barycentric triangle locator.
// Widths, word types and shared constants; no dependencies.
`timescale 1ns / 1ps

package tbl_pkg;

    localparam int COORD_W  = 16;
    localparam int FRAC_W   = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int NA_W     = CROSS_W + 2;
    localparam int MAG_W    = CROSS_W;
    localparam int WGT_W    = 32;
    localparam int QUO_W    = WGT_W + 1;
    localparam int NUM_W    = MAG_W + FRAC_W;
    localparam int OVF_SH   = QUO_W - FRAC_W;
    localparam int OVF_W    = MAG_W + OVF_SH + 1;
    localparam int SUM_W    = WGT_W + 2;
    localparam int N_CELLS  = QUO_W;

    // one quotient lane: partial remainder, numerator bits still to shift in, quotient so far
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] sh;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } tbl_lane_t;

    typedef struct packed {
        logic [MAG_W-1:0] dmag;
        tbl_lane_t        lane_b;
        tbl_lane_t        lane_c;
        logic             in_tri;
        logic             degen;
    } tbl_cell_t;

endpackage

[hdl/triangle_barycentric_locate.sv]
// Top level of the barycentric triangle locator: front end, divider cell chain, back end.
// Uses tbl_pkg, tbl_front, tbl_div_cell, tbl_out.
//
//  channel  dir  tdata                                   tuser
//  s_axis   in   a_x a_y b_x b_y c_x c_y p_x p_y (128)  -
//  m_axis   out  weight_a weight_b weight_c (96)         inside_res degenerate
//
// One word per cycle while the output is not stalled; 4 front stages, 33 divider cells
// (one quotient bit each), 2 back-end stages.
// Every stage holds its own valid, so bubbles close up under a stall.
// Reset clears the valid bits only.
`timescale 1ns / 1ps

module triangle_barycentric_locate
    import tbl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // weight_a, weight_b, weight_c
    output logic [1:0]   m_axis_tuser   // inside_res, degenerate
);

    logic signed [COORD_W-1:0] crd [8];
    logic      cv [N_CELLS+1];
    logic      cr [N_CELLS+1];
    tbl_cell_t cc [N_CELLS+1];
    logic signed [WGT_W-1:0] wa, wb, wc;
    logic ins, dgn;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            crd[i] = s_axis_tdata[i*COORD_W +: COORD_W];
    end

    tbl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .crd       (crd),
        .out_valid (cv[0]),
        .out_ready (cr[0]),
        .out_cell  (cc[0])
    );

    for (genvar g = 0; g < N_CELLS; g++)
    begin : g_cell
        tbl_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[g]),
            .in_ready  (cr[g]),
            .in_cell   (cc[g]),
            .out_valid (cv[g+1]),
            .out_ready (cr[g+1]),
            .out_cell  (cc[g+1])
        );
    end

    tbl_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cv[N_CELLS]),
        .in_ready   (cr[N_CELLS]),
        .in_cell    (cc[N_CELLS]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .weight_a   (wa),
        .weight_b   (wb),
        .weight_c   (wc),
        .inside_res (ins),
        .degenerate (dgn)
    );

    assign m_axis_tdata = {wc, wb, wa};
    assign m_axis_tuser = {dgn, ins};

endmodule

[hdl/tbl_front.sv]
// Front end: edge vectors, cross products, determinant, numerator magnitudes and signs, inside and degenerate tests.
// Four registered stages; uses tbl_pkg.
`timescale 1ns / 1ps

module tbl_front
    import tbl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] crd [8],
    output logic                      out_valid,
    input  logic                      out_ready,
    output tbl_cell_t                 out_cell
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;

    logic signed [DIFF_W-1:0]  dif_reg  [6];
    logic signed [PROD_W-1:0]  prd_reg  [6];
    logic signed [CROSS_W-1:0] det_reg, nb_reg, nc_reg;
    tbl_cell_t                 cell_reg;

    logic signed [DIFF_W-1:0]  dif_next [6];
    logic signed [NA_W-1:0]    na;
    logic [MAG_W-1:0]          mb, mc, md;
    logic [NUM_W-1:0]          numb, numc;
    logic [OVF_W-1:0]          dlim;
    logic                      sd_pos;
    tbl_cell_t                 cell_next;

    assign ld4      = !v4_reg || out_ready;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    always_comb
    begin
        dif_next[0] = DIFF_W'(crd[2]) - DIFF_W'(crd[0]);
        dif_next[1] = DIFF_W'(crd[3]) - DIFF_W'(crd[1]);
        dif_next[2] = DIFF_W'(crd[4]) - DIFF_W'(crd[0]);
        dif_next[3] = DIFF_W'(crd[5]) - DIFF_W'(crd[1]);
        dif_next[4] = DIFF_W'(crd[6]) - DIFF_W'(crd[0]);
        dif_next[5] = DIFF_W'(crd[7]) - DIFF_W'(crd[1]);
    end

    always_comb
    begin
        na     = NA_W'(det_reg) - NA_W'(nb_reg) - NA_W'(nc_reg);
        md     = det_reg[CROSS_W-1] ? MAG_W'(-det_reg) : MAG_W'(det_reg);
        mb     = nb_reg[CROSS_W-1]  ? MAG_W'(-nb_reg)  : MAG_W'(nb_reg);
        mc     = nc_reg[CROSS_W-1]  ? MAG_W'(-nc_reg)  : MAG_W'(nc_reg);
        numb   = {mb, {FRAC_W{1'b0}}};
        numc   = {mc, {FRAC_W{1'b0}}};
        dlim   = OVF_W'(md) << OVF_SH;
        sd_pos = !det_reg[CROSS_W-1];

        cell_next.dmag        = md;
        cell_next.degen       = (det_reg == '0);
        cell_next.in_tri      = (det_reg != '0) && (sd_pos
                                ? (!na[NA_W-1] && !nb_reg[CROSS_W-1] && !nc_reg[CROSS_W-1])
                                : (na <= 0 && nb_reg <= 0 && nc_reg <= 0));
        cell_next.lane_b.rem  = MAG_W'(numb[NUM_W-1:QUO_W]);
        cell_next.lane_b.sh   = numb[QUO_W-1:0];
        cell_next.lane_b.quo  = '0;
        cell_next.lane_b.neg  = nb_reg[CROSS_W-1] ^ det_reg[CROSS_W-1];
        cell_next.lane_b.ovf  = OVF_W'(mb) >= dlim;
        cell_next.lane_c.rem  = MAG_W'(numc[NUM_W-1:QUO_W]);
        cell_next.lane_c.sh   = numc[QUO_W-1:0];
        cell_next.lane_c.quo  = '0;
        cell_next.lane_c.neg  = nc_reg[CROSS_W-1] ^ det_reg[CROSS_W-1];
        cell_next.lane_c.ovf  = OVF_W'(mc) >= dlim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
            dif_reg <= dif_next;
        if (ld2)
        begin
            prd_reg[0] <= dif_reg[0] * dif_reg[3];
            prd_reg[1] <= dif_reg[2] * dif_reg[1];
            prd_reg[2] <= dif_reg[4] * dif_reg[3];
            prd_reg[3] <= dif_reg[2] * dif_reg[5];
            prd_reg[4] <= dif_reg[0] * dif_reg[5];
            prd_reg[5] <= dif_reg[4] * dif_reg[1];
        end
        if (ld3)
        begin
            det_reg <= CROSS_W'(prd_reg[0]) - CROSS_W'(prd_reg[1]);
            nb_reg  <= CROSS_W'(prd_reg[2]) - CROSS_W'(prd_reg[3]);
            nc_reg  <= CROSS_W'(prd_reg[4]) - CROSS_W'(prd_reg[5]);
        end
        if (ld4)
            cell_reg <= cell_next;
    end

    assign out_valid = v4_reg;
    assign out_cell  = cell_reg;

endmodule

[hdl/tbl_div_cell.sv]
// One cell of the divider chain: one quotient bit for each of the B and C lanes.
// Uses tbl_pkg.
`timescale 1ns / 1ps

module tbl_div_cell
    import tbl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  tbl_cell_t in_cell,
    output logic      out_valid,
    input  logic      out_ready,
    output tbl_cell_t out_cell
);

    logic      v_reg;
    tbl_cell_t cell_reg;
    tbl_cell_t cell_next;

    function automatic tbl_lane_t step(input tbl_lane_t ln, input logic [MAG_W-1:0] d);
        tbl_lane_t         o;
        logic [MAG_W:0]    t;
        logic [MAG_W:0]    s;
        o = ln;
        t = {ln.rem, ln.sh[QUO_W-1]};
        s = t - {1'b0, d};
        o.sh = ln.sh << 1;
        if (t >= {1'b0, d})
        begin
            o.rem = s[MAG_W-1:0];
            o.quo = {ln.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = t[MAG_W-1:0];
            o.quo = {ln.quo[QUO_W-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb
    begin
        cell_next        = in_cell;
        cell_next.lane_b = step(in_cell.lane_b, in_cell.dmag);
        cell_next.lane_c = step(in_cell.lane_c, in_cell.dmag);
    end

    assign in_ready = !v_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            cell_reg <= cell_next;
    end

    assign out_valid = v_reg;
    assign out_cell  = cell_reg;

endmodule

[hdl/tbl_out.sv]
// Back end: sign and saturation of B and C weights, A weight, output register.
// Uses tbl_pkg.
`timescale 1ns / 1ps

module tbl_out
    import tbl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  tbl_cell_t               in_cell,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [WGT_W-1:0] weight_a,
    output logic signed [WGT_W-1:0] weight_b,
    output logic signed [WGT_W-1:0] weight_c,
    output logic                    inside_res,
    output logic                    degenerate
);

    localparam logic [QUO_W-1:0] LIM = QUO_W'(1) << (WGT_W - 1);
    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_W;
    localparam logic signed [SUM_W-1:0] SMAX = SUM_W'({1'b0, {(WGT_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

    logic v1_reg, v2_reg, ld1, ld2;
    logic signed [WGT_W-1:0] wb_reg, wc_reg, wa_reg, wb2_reg, wc2_reg;
    logic in1_reg, dg1_reg, in2_reg, dg2_reg;
    logic signed [WGT_W-1:0] wb_next, wc_next;
    logic signed [SUM_W-1:0] sum;

    function automatic logic [WGT_W-1:0] sat(input tbl_lane_t ln, input logic dg);
        logic [WGT_W-1:0] r;
        if (dg)
            r = '0;
        else if (!ln.neg)
            r = (ln.ovf || ln.quo >= LIM) ? {1'b0, {(WGT_W-1){1'b1}}} : ln.quo[WGT_W-1:0];
        else if (ln.ovf || ln.quo > LIM)
            r = {1'b1, {(WGT_W-1){1'b0}}};
        else
            r = -ln.quo[WGT_W-1:0];
        return r;
    endfunction

    assign wb_next = sat(in_cell.lane_b, in_cell.degen);
    assign wc_next = sat(in_cell.lane_c, in_cell.degen);
    assign sum     = ONE - SUM_W'(wb_reg) - SUM_W'(wc_reg);

    assign ld2      = !v2_reg || out_ready;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            wb_reg  <= wb_next;
            wc_reg  <= wc_next;
            in1_reg <= in_cell.in_tri;
            dg1_reg <= in_cell.degen;
        end
        if (ld2)
        begin
            wb2_reg <= wb_reg;
            wc2_reg <= wc_reg;
            in2_reg <= in1_reg;
            dg2_reg <= dg1_reg;
            if (dg1_reg)
                wa_reg <= '0;
            else if (sum > SMAX)
                wa_reg <= SMAX[WGT_W-1:0];
            else if (sum < SMIN)
                wa_reg <= SMIN[WGT_W-1:0];
            else
                wa_reg <= sum[WGT_W-1:0];
        end
    end

    assign out_valid  = v2_reg;
    assign weight_a   = wa_reg;
    assign weight_b   = wb2_reg;
    assign weight_c   = wc2_reg;
    assign inside_res = in2_reg;
    assign degenerate = dg2_reg;

endmodule

[tb/tb_top.sv]
// Testbench for triangle_barycentric_locate: random and directed triangles with query points.
// Depends on tbl_pkg and the RTL; a small scoreboard class predicts and checks weights and flags.
`timescale 1ns / 1ps

class bary_scoreboard;
    typedef struct {
        logic signed [31:0] wa;
        logic signed [31:0] wb;
        logic signed [31:0] wc;
        logic               in_tri;
        logic               degen;
    } bary_res_t;

    bary_res_t pending[$];
    int        errors = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // truncated fixed-point quotient, saturated to 32 bits
    function automatic longint fix_quot(longint num, longint den);
        longint nm;
        longint dm;
        longint q0;
        longint r;
        longint mag;
        bit     neg;
        neg = (num < 0) != (den < 0);
        nm  = (num < 0) ? -num : num;
        dm  = (den < 0) ? -den : den;
        q0  = nm / dm;
        r   = nm % dm;
        if (q0 > ((64'sd1 << 31) >>> tbl_pkg::FRAC_W))
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        mag = (q0 << tbl_pkg::FRAC_W) + ((r << tbl_pkg::FRAC_W) / dm);
        if (neg)
            mag = -mag;
        return sat32(mag);
    endfunction

    function void note_triangle(logic [127:0] w);
        longint    k[8];
        longint    bx, by, cx, cy, px, py, det, nb, nc, na, wb, wc;
        bary_res_t e;
        for (int i = 0; i < 8; i++)
            k[i] = longint'($signed(w[16*i +: 16]));
        bx  = k[2] - k[0];
        by  = k[3] - k[1];
        cx  = k[4] - k[0];
        cy  = k[5] - k[1];
        px  = k[6] - k[0];
        py  = k[7] - k[1];
        det = bx * cy - cx * by;
        nb  = px * cy - cx * py;
        nc  = bx * py - px * by;
        na  = det - nb - nc;
        if (det == 0) begin
            e = '{0, 0, 0, 1'b0, 1'b1};
        end
        else begin
            wb     = fix_quot(nb, det);
            wc     = fix_quot(nc, det);
            e.wb   = wb[31:0];
            e.wc   = wc[31:0];
            e.wa   = 32'(sat32((64'sd1 << tbl_pkg::FRAC_W) - wb - wc));
            e.in_tri = (det > 0) ? (na >= 0 && nb >= 0 && nc >= 0)
                                 : (na <= 0 && nb <= 0 && nc <= 0);
            e.degen  = 1'b0;
        end
        pending.push_back(e);
    endfunction

    function void check_weights(logic [95:0] d, logic [1:0] u);
        bary_res_t e;
        if (pending.size() == 0) begin
            $error("unexpected word %h / %b", d, u);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d[31:0] !== e.wa) begin
            $error("weight_a exp %h got %h", e.wa, d[31:0]);
            errors++;
        end
        if (d[63:32] !== e.wb) begin
            $error("weight_b exp %h got %h", e.wb, d[63:32]);
            errors++;
        end
        if (d[95:64] !== e.wc) begin
            $error("weight_c exp %h got %h", e.wc, d[95:64]);
            errors++;
        end
        if (u[0] !== e.in_tri) begin
            $error("inside_res exp %b got %b", e.in_tri, u[0]);
            errors++;
        end
        if (u[1] !== e.degen) begin
            $error("degenerate exp %b got %b", e.degen, u[1]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import tbl_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    bary_scoreboard sb = new();
    int send_idle = 0;
    int recv_stall = 0;

    triangle_barycentric_locate DUT (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_weights(m_axis_tdata, m_axis_tuser);

    always @(negedge clk)
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall);

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(40)) - 20);
            default: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    task automatic send_triangle(logic [127:0] w);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_triangle(w);
        @(negedge clk);
    endtask

    function automatic logic [127:0] pack_tri(int ax, int ay, int bx, int by,
                                               int cx, int cy, int px, int py);
        return {16'(py), 16'(px), 16'(cy), 16'(cx), 16'(by), 16'(bx), 16'(ay), 16'(ax)};
    endfunction

    initial begin
        logic [127:0] w;
        int mode;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_triangle(pack_tri(0, 0, 10, 0, 0, 10, 3, 3));
        send_triangle(pack_tri(0, 0, 10, 0, 0, 10, 20, 20));
        send_triangle(pack_tri(0, 0, 0, 10, 10, 0, 3, 3));
        send_triangle(pack_tri(0, 0, 10, 0, 0, 10, 0, 0));
        send_triangle(pack_tri(0, 0, 10, 0, 0, 10, 5, 5));
        send_triangle(pack_tri(0, 0, 5, 5, 10, 10, 1, 2));
        send_triangle(pack_tri(1, 1, 1, 1, 1, 1, 1, 1));
        send_triangle(pack_tri(0, 0, 1, 0, 0, 1, 32767, -32768));
        send_triangle(pack_tri(0, 0, 1, 0, 0, 1, -32768, 32767));
        send_triangle(pack_tri(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
        send_triangle(pack_tri(32767, 32767, -32768, 32767, 32767, -32768,
                               -32768, -32768));
        send_triangle(pack_tri(-32768, 32767, 32767, 32767, -32768, -32768,
                               32767, -32768));
        send_triangle(pack_tri(0, 0, 1, 0, 0, 1, 1, 0));
        send_triangle(pack_tri(0, 0, 3, 0, 0, 3, 1, 1));
        send_triangle(pack_tri(0, 0, 3, 0, 0, 7, -1, -2));
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 72 : 8) : 0;
            recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 72 : 8) : 0;
            for (int n = 0; n < 260; n++) begin
                mode = $urandom_range(9);
                for (int i = 0; i < 8; i++)
                    w[16*i +: 16] = rand_coord(mode < 5 ? 0 : (mode < 9 ? 1 : 2));
                if (mode == 8)
                    w[127:112] = w[15:0] + 16'($urandom_range(3));
                send_triangle(w);
            end
        end
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end
endmodule
